// ===== hdl/sparse_fragmented_array_table_unit_macros.svh =====
// Assertion macros shared by the sparse paged array table modules
`ifndef SPARSE_FRAGMENTED_ARRAY_TABLE_UNIT_MACROS_SVH
`define SPARSE_FRAGMENTED_ARRAY_TABLE_UNIT_MACROS_SVH

// check cons in the same cycle as ante
`define SFAT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// check cons starting in the cycle after ante
`define SFAT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/sfat_pkg.sv =====
// Types and constants of the sparse paged array table
package sfat_pkg;

  localparam int OP_W   = 3;
  localparam int IDX_W  = 16;
  localparam int KEY_W  = 32;
  localparam int ST_W   = 2;
  localparam int CNT_W  = 9;
  localparam int ACT_W  = 5;

  localparam int RECIP_SH = 24;
  localparam int RECIP_W  = RECIP_SH + 1;

  typedef enum logic [OP_W-1:0] {
    OP_SET      = 3'd0,
    OP_GET      = 3'd1,
    OP_DEL      = 3'd2,
    OP_CONTAINS = 3'd3,
    OP_IS_SET   = 3'd4,
    OP_CLEAR    = 3'd5
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic occupy;
    logic vacate;
    logic clear_all;
  } occ_cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] total;
    logic [ACT_W-1:0] active;
    logic [CNT_W-1:0] alloc;
  } occ_cnt_t;

endpackage

// ===== hdl/sfat_if.sv =====
// Operation and result channel interfaces
interface sfat_in_if;
  logic                              valid;
  logic                              ready;
  logic [sfat_pkg::OP_W-1:0]         op;
  logic [sfat_pkg::IDX_W-1:0]        index;
  logic signed [sfat_pkg::KEY_W-1:0] key;

  modport source (output valid, op, index, key, input ready);
  modport sink   (input valid, op, index, key, output ready);
endinterface

interface sfat_out_if;
  logic                              valid;
  logic                              ready;
  logic [sfat_pkg::ST_W-1:0]         status;
  logic signed [sfat_pkg::KEY_W-1:0] read_value;
  logic                              hit;
  logic [sfat_pkg::CNT_W-1:0]        element_count;
  logic [sfat_pkg::ACT_W-1:0]        active_fragments;
  logic [sfat_pkg::CNT_W-1:0]        allocated_cells;

  modport source (output valid, status, read_value, hit, element_count, active_fragments,
                  allocated_cells, input ready);
  modport sink   (input valid, status, read_value, hit, element_count, active_fragments,
                  allocated_cells, output ready);
endinterface

// ===== hdl/sfat_ram.sv =====
// Generic single-write, single-read RAM with registered read data
module sfat_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

endmodule

// ===== hdl/sfat_occ.sv =====
// Occupancy counts: per-fragment cell counts, total, active fragments and allocated cells
`include "sparse_fragmented_array_table_unit_macros.svh"

module sfat_occ #(
  parameter int NUM_FRAGS = 16,
  parameter int FRAG_LEN  = 16,
  localparam int FW = (NUM_FRAGS > 1) ? $clog2(NUM_FRAGS) : 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  sfat_pkg::occ_cmd_t cmd,
  input  logic [FW-1:0]      frag_idx,
  output sfat_pkg::occ_cnt_t cnt
);

  localparam int FCW = $clog2(FRAG_LEN + 1);
  localparam logic [FCW-1:0] FRAG_FULL = FCW'(FRAG_LEN);
  localparam logic [sfat_pkg::CNT_W-1:0] FRAG_INC = sfat_pkg::CNT_W'(FRAG_LEN);

  logic [FCW-1:0]     frag_cnt_r [NUM_FRAGS];
  sfat_pkg::occ_cnt_t cnt_r;

  assign cnt = cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear_all) begin
      for (int f = 0; f < NUM_FRAGS; f++) begin
        frag_cnt_r[f] <= '0;
      end
      cnt_r <= '0;
    end else if (cmd.occupy) begin
      frag_cnt_r[frag_idx] <= frag_cnt_r[frag_idx] + FCW'(1);
      cnt_r.total          <= cnt_r.total + sfat_pkg::CNT_W'(1);
      if (frag_cnt_r[frag_idx] == '0) begin
        cnt_r.active <= cnt_r.active + sfat_pkg::ACT_W'(1);
        cnt_r.alloc  <= cnt_r.alloc + FRAG_INC;
      end
    end else if (cmd.vacate) begin
      frag_cnt_r[frag_idx] <= frag_cnt_r[frag_idx] - FCW'(1);
      cnt_r.total          <= cnt_r.total - sfat_pkg::CNT_W'(1);
      if (frag_cnt_r[frag_idx] == FCW'(1)) begin
        cnt_r.active <= cnt_r.active - sfat_pkg::ACT_W'(1);
        cnt_r.alloc  <= cnt_r.alloc - FRAG_INC;
      end
    end
  end

  `SFAT_ASSERT_SAME(a_cmd_onehot, 1'b1, $onehot0(cmd), "overlapping occupancy commands")
  `SFAT_ASSERT_SAME(a_occupy_room, cmd.occupy, frag_cnt_r[frag_idx] != FRAG_FULL, "fragment full")
  `SFAT_ASSERT_SAME(a_vacate_live, cmd.vacate, frag_cnt_r[frag_idx] != '0, "fragment empty")
  `SFAT_ASSERT_NEXT(a_clear_zero, cmd.clear_all, cnt_r == '0, "counts not zero after clear")

endmodule

// ===== hdl/sparse_fragmented_array_table_unit.sv =====
// Top level of the sparse paged array table
// Sparse paged array of NUM_FRAGS x FRAG_LEN signed 32-bit cells. Each operation transaction
// returns one result transaction carrying status, read value, hit flag and the occupied,
// active-fragment and allocated-cell counts after the operation. Set, get, delete, is_set,
// clear and unused codes read the value RAM as they are accepted, then in the execute state update
// occupancy, write back and load the result register. Contains walks the value RAM one cell per
// cycle through its single read port, ending early on the first occupied cell that matches.
// Each cell's valid bit sits beside its value in the RAM, so clear, after loading its result,
// holds the input off while it wipes the valid bits one cell per cycle; the same wipe runs
// after reset, so the first operation is taken only once that wipe is done. Otherwise the next
// operation is taken in the cycle after the result is loaded, as long as the result register
// is free or being drained. Fragment counts and totals all clear as clear loads its result.
`include "sparse_fragmented_array_table_unit_macros.svh"

module sparse_fragmented_array_table_unit #(
  parameter int NUM_FRAGS = 16,
  parameter int FRAG_LEN  = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  sfat_in_if.sink    in_chan,
  sfat_out_if.source out_chan
);

  localparam int CAP = NUM_FRAGS * FRAG_LEN;
  localparam int IW  = (CAP > 1) ? $clog2(CAP) : 1;
  localparam int FW  = (NUM_FRAGS > 1) ? $clog2(NUM_FRAGS) : 1;
  localparam int PW  = sfat_pkg::IDX_W + sfat_pkg::RECIP_W;
  localparam int DW  = sfat_pkg::KEY_W + 1;
  localparam logic [IW-1:0] LAST = IW'(CAP - 1);
  localparam logic [sfat_pkg::IDX_W:0] CAP_X = (sfat_pkg::IDX_W + 1)'(CAP);
  localparam logic [sfat_pkg::RECIP_W-1:0] RECIP =
    sfat_pkg::RECIP_W'(((2 ** sfat_pkg::RECIP_SH) + FRAG_LEN - 1) / FRAG_LEN);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_WIPE
  } state_t;

  state_t                            state_r, state_nxt;
  logic [sfat_pkg::OP_W-1:0]         op_r, op_nxt;
  logic [IW-1:0]                     idx_r, idx_nxt;
  logic [FW-1:0]                     frag_r, frag_nxt;
  logic signed [sfat_pkg::KEY_W-1:0] key_r, key_nxt;
  logic                              rng_r, rng_nxt;
  logic [IW-1:0]                     ptr_r, ptr_nxt;
  logic                              run_r, run_nxt;
  logic                              chk_vld_r, chk_vld_nxt;
  logic [IW-1:0]                     chk_idx_r, chk_idx_nxt;
  logic                              out_vld_r, out_vld_nxt;
  sfat_pkg::status_t                 st_r, st_nxt;
  logic signed [sfat_pkg::KEY_W-1:0] rv_r, rv_nxt;
  logic                              hit_r, hit_nxt;

  logic                              in_acc;
  logic                              in_scan;
  logic [PW-1:0]                     prod;
  logic                              ram_we;
  logic [IW-1:0]                     ram_waddr;
  logic [DW-1:0]                     ram_wdata;
  logic [IW-1:0]                     ram_raddr;
  logic [DW-1:0]                     ram_rdata;
  logic                              match;
  sfat_pkg::occ_cmd_t                cmd;
  sfat_pkg::occ_cnt_t                cnt;
  logic                              cell_vld;

  sfat_ram #(
    .WIDTH (DW),
    .DEPTH (CAP)
  ) u_val_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr   (ram_raddr),
    .rdata_r (ram_rdata)
  );

  sfat_occ #(
    .NUM_FRAGS (NUM_FRAGS),
    .FRAG_LEN  (FRAG_LEN)
  ) u_occ (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .frag_idx (frag_r),
    .cnt      (cnt)
  );

  assign in_chan.ready = (state_r == S_IDLE) && (!out_vld_r || out_chan.ready);
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign in_scan       = in_chan.op == sfat_pkg::OP_CONTAINS;
  assign prod          = PW'(in_chan.index) * PW'(RECIP);
  assign cell_vld      = ram_rdata[sfat_pkg::KEY_W];
  assign match         = cell_vld && (ram_rdata[sfat_pkg::KEY_W-1:0] == key_r);

  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    idx_nxt     = idx_r;
    frag_nxt    = frag_r;
    key_nxt     = key_r;
    rng_nxt     = rng_r;
    ptr_nxt     = ptr_r;
    run_nxt     = run_r;
    chk_vld_nxt = chk_vld_r;
    chk_idx_nxt = chk_idx_r;
    out_vld_nxt = out_vld_r && !out_chan.ready;
    st_nxt      = st_r;
    rv_nxt      = rv_r;
    hit_nxt     = hit_r;
    cmd         = '0;
    ram_we      = 1'b0;
    ram_waddr   = idx_r;
    ram_wdata   = {1'b1, key_r};
    ram_raddr   = idx_r;

    unique case (state_r)
      S_IDLE: begin
        ram_raddr = in_chan.index[IW-1:0];
        if (in_acc) begin
          op_nxt   = in_chan.op;
          idx_nxt  = in_chan.index[IW-1:0];
          frag_nxt = prod[sfat_pkg::RECIP_SH +: FW];
          key_nxt  = in_chan.key;
          rng_nxt  = {1'b0, in_chan.index} < CAP_X;
          if (in_scan) begin
            state_nxt   = S_SCAN;
            ptr_nxt     = '0;
            run_nxt     = 1'b1;
            chk_vld_nxt = 1'b0;
          end else begin
            state_nxt = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        st_nxt      = sfat_pkg::ST_OK;
        rv_nxt      = '0;
        hit_nxt     = 1'b0;
        out_vld_nxt = 1'b1;
        state_nxt   = S_IDLE;
        unique case (op_r)
          sfat_pkg::OP_SET: begin
            if (!rng_r) begin
              st_nxt = sfat_pkg::ST_RANGE;
            end else begin
              ram_we     = 1'b1;
              cmd.occupy = !cell_vld;
            end
          end
          sfat_pkg::OP_GET: begin
            if (!rng_r) begin
              st_nxt = sfat_pkg::ST_RANGE;
            end else if (!cell_vld) begin
              st_nxt = sfat_pkg::ST_EMPTY;
            end else begin
              rv_nxt = ram_rdata[sfat_pkg::KEY_W-1:0];
            end
          end
          sfat_pkg::OP_DEL: begin
            if (!rng_r) begin
              st_nxt = sfat_pkg::ST_RANGE;
            end else if (!cell_vld) begin
              st_nxt = sfat_pkg::ST_EMPTY;
            end else begin
              ram_we     = 1'b1;
              ram_wdata  = '0;
              cmd.vacate = 1'b1;
            end
          end
          sfat_pkg::OP_IS_SET: begin
            if (!rng_r) begin
              st_nxt = sfat_pkg::ST_RANGE;
            end else begin
              hit_nxt = cell_vld;
            end
          end
          sfat_pkg::OP_CLEAR: begin
            cmd.clear_all = 1'b1;
            ptr_nxt       = '0;
            state_nxt     = S_WIPE;
          end
          default: begin
          end
        endcase
      end
      S_SCAN: begin
        ram_raddr   = ptr_r;
        chk_vld_nxt = run_r;
        chk_idx_nxt = ptr_r;
        if (run_r) begin
          if (ptr_r == LAST) begin
            run_nxt = 1'b0;
          end else begin
            ptr_nxt = ptr_r + IW'(1);
          end
        end
        if (chk_vld_r && (match || chk_idx_r == LAST)) begin
          st_nxt      = sfat_pkg::ST_OK;
          rv_nxt      = '0;
          hit_nxt     = match;
          out_vld_nxt = 1'b1;
          run_nxt     = 1'b0;
          chk_vld_nxt = 1'b0;
          state_nxt   = S_IDLE;
        end
      end
      S_WIPE: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_r;
        ram_wdata = '0;
        if (ptr_r == LAST) begin
          state_nxt = S_IDLE;
        end else begin
          ptr_nxt = ptr_r + IW'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_WIPE;
      ptr_r     <= '0;
      run_r     <= 1'b0;
      chk_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      ptr_r     <= ptr_nxt;
      run_r     <= run_nxt;
      chk_vld_r <= chk_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
    op_r      <= op_nxt;
    idx_r     <= idx_nxt;
    frag_r    <= frag_nxt;
    key_r     <= key_nxt;
    rng_r     <= rng_nxt;
    chk_idx_r <= chk_idx_nxt;
    st_r      <= st_nxt;
    rv_r      <= rv_nxt;
    hit_r     <= hit_nxt;
  end

  assign out_chan.valid            = out_vld_r;
  assign out_chan.status           = st_r;
  assign out_chan.read_value       = rv_r;
  assign out_chan.hit              = hit_r;
  assign out_chan.element_count    = cnt.total;
  assign out_chan.active_fragments = cnt.active;
  assign out_chan.allocated_cells  = cnt.alloc;

  `SFAT_ASSERT_SAME(a_exec_out_free, state_r == S_EXEC, !out_vld_r, "result register busy")
  `SFAT_ASSERT_NEXT(a_op_result, in_acc && !in_scan, ##1 out_vld_r, "no result after operation")
  `SFAT_ASSERT_SAME(a_chk_in_scan, chk_vld_r, state_r == S_SCAN, "compare pending outside scan")
  `SFAT_ASSERT_SAME(a_wipe_hold, state_r == S_WIPE, !in_chan.ready, "input open during wipe")

endmodule
